// File: rtl/core/fys_pkg.sv
// shared types and constants for the fisher-yates shuffle core
package fys_pkg;

  // fixed field widths
  localparam int RAND_W     = 31;
  localparam int POS_W      = 6;
  localparam int CARD_W     = 6;

  // parameter defaults
  localparam int              DEF_DECK_SIZE  = 52;
  localparam longint unsigned DEF_RANDOM_MAX = 64'd2147483647;

  // request codes
  typedef enum logic [0:0] {
    OP_RESTORE = 1'b0,
    OP_SHUFFLE = 1'b1
  } op_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_READ,
    ST_SWAP_I,
    ST_SWAP_J,
    ST_DONE
  } state_t;

  // divider start request
  typedef struct packed {
    logic              start;
    logic [RAND_W-1:0] dividend;
  } div_req_t;

  // divider result
  typedef struct packed {
    logic              done;
    logic [RAND_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/core/fys_ram.sv
// generic one-write two-read ram with registered read data
module fys_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: rtl/core/fys_divider.sv
// restoring divider, one quotient bit per cycle
module fys_divider #(
  parameter int DIVISOR_W = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  fys_pkg::div_req_t    req,
  input  logic [DIVISOR_W-1:0] divisor,
  output fys_pkg::div_rsp_t    rsp
);
  import fys_pkg::*;

  localparam int CW = $clog2(RAND_W);

  logic                 busy;
  logic                 done;
  logic [CW-1:0]        count;
  logic [RAND_W-1:0]    quo;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dvs;

  logic [DIVISOR_W:0]   rem_shift;
  logic                 fits;
  logic [DIVISOR_W:0]   rem_diff;

  // one shift-subtract step
  always_comb begin
    rem_shift = {rem, quo[RAND_W-1]};
    fits      = (rem_shift >= {1'b0, dvs});
    rem_diff  = rem_shift - {1'b0, dvs};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + CW'(1);
        if (count == CW'(RAND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[RAND_W-2:0], fits};
      rem <= fits ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// File: rtl/core/fisher_yates_shuffle_core.sv
// fisher-yates shuffle core: sequencer, deck store and shared divider
//
//  channel  signals                          direction  request
//  in       in_valid in_stall op random_word  in         restore or one shuffle step
//  out      out_valid out_stall position       out        fixed position, its card,
//           card pass_done                                 end-of-pass flag
//
// a shuffle request passes through acceptance, the divider (one quotient bit per
// cycle of random_word / step divisor, then a registered done), the deck read,
// two swap writes on the single ram write port, and delivery into the output
// register. a restore request gives no result.
// reset clears the walk position and the per-entry valid bits at once; an entry
// never written reads as its own index, so there is no clearing pass.
// the core takes a new request while a result waits in the output register; a
// finished step waits in its last state until that register is free.
module fisher_yates_shuffle_core #(
  parameter int              DECK_SIZE  = fys_pkg::DEF_DECK_SIZE,
  parameter longint unsigned RANDOM_MAX = fys_pkg::DEF_RANDOM_MAX
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      op,
  input  logic [fys_pkg::RAND_W-1:0] random_word,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [fys_pkg::POS_W-1:0]  position,
  output logic [fys_pkg::CARD_W-1:0] card,
  output logic                      pass_done
);
  import fys_pkg::*;

  localparam int PW    = $clog2(DECK_SIZE);
  localparam int DIV_W = $clog2(RANDOM_MAX + 64'd2);
  localparam logic [PW-1:0] LAST_POS = PW'(DECK_SIZE - 1);

  state_t state, state_next;

  logic [PW-1:0]        walk;
  logic [PW-1:0]        i_q;
  logic [PW-1:0]        j_q;
  logic [PW-1:0]        held_i;
  logic [PW-1:0]        card_q;
  logic [DECK_SIZE-1:0] valid_bits;

  logic in_take;
  logic out_free;

  // step divisor table, worked out at elaboration
  logic [DIV_W-1:0] div_table [DECK_SIZE];
  for (genvar k = 0; k < DECK_SIZE; k++) begin : g_div_table
    localparam longint unsigned DVAL = RANDOM_MAX / 64'(DECK_SIZE - k) + 64'd1;
    assign div_table[k] = DVAL[DIV_W-1:0];
  end

  // shared divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  fys_divider #(
    .DIVISOR_W (DIV_W)
  ) u_divider (
    .clk     (clk),
    .rst     (rst),
    .req     (div_req),
    .divisor (div_table[walk]),
    .rsp     (div_rsp)
  );

  // deck store
  logic          ram_we;
  logic [PW-1:0] ram_waddr;
  logic [PW-1:0] ram_wdata;
  logic [PW-1:0] ram_rdata_a;
  logic [PW-1:0] ram_rdata_b;

  fys_ram #(
    .WIDTH (PW),
    .DEPTH (DECK_SIZE)
  ) u_deck (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (i_q),
    .raddr_b (j_q),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  // entries never written read as identity
  logic [PW-1:0] card_at_i;
  logic [PW-1:0] card_at_j;
  assign card_at_i = valid_bits[i_q] ? ram_rdata_a : i_q;
  assign card_at_j = valid_bits[j_q] ? ram_rdata_b : j_q;

  // swap partner from the quotient, saturated at the deck end
  logic [PW-1:0] offs_max;
  logic [PW-1:0] j_calc;
  always_comb begin
    offs_max = LAST_POS - i_q;
    if (div_rsp.quotient > RAND_W'(offs_max)) begin
      j_calc = LAST_POS;
    end else begin
      j_calc = i_q + div_rsp.quotient[PW-1:0];
    end
  end

  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_take && (op == OP_SHUFFLE)) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_rsp.done) begin
          state_next = ST_READ;
        end
      end
      ST_READ:   state_next = ST_SWAP_I;
      ST_SWAP_I: state_next = ST_SWAP_J;
      ST_SWAP_J: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall         = 1'b1;
    div_req.start    = 1'b0;
    div_req.dividend = random_word;
    ram_we           = 1'b0;
    ram_waddr        = i_q;
    ram_wdata        = card_at_j;
    unique case (state)
      ST_IDLE: begin
        in_stall      = 1'b0;
        div_req.start = in_valid && (op == OP_SHUFFLE);
      end
      ST_SWAP_I: begin
        ram_we    = 1'b1;
        ram_waddr = i_q;
        ram_wdata = card_at_j;
      end
      ST_SWAP_J: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = held_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // walk position and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      walk       <= '0;
      valid_bits <= '0;
    end else begin
      if (state == ST_IDLE && in_take && (op == OP_RESTORE)) begin
        walk       <= '0;
        valid_bits <= '0;
      end
      if (ram_we) begin
        valid_bits[ram_waddr] <= 1'b1;
      end
      if (state == ST_DONE && out_free) begin
        walk <= (i_q == LAST_POS) ? '0 : i_q + PW'(1);
      end
    end
  end

  // step datapath
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      i_q <= walk;
    end
    if (state == ST_DIVIDE && div_rsp.done) begin
      j_q <= j_calc;
    end
    if (state == ST_SWAP_I) begin
      held_i <= card_at_i;
      card_q <= card_at_j;
    end
  end

  // output register
  logic [PW+POS_W-1:0]  pos_ext;
  logic [PW+CARD_W-1:0] card_ext;
  assign pos_ext  = {{POS_W{1'b0}}, i_q};
  assign card_ext = {{CARD_W{1'b0}}, card_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      position  <= pos_ext[POS_W-1:0];
      card      <= card_ext[CARD_W-1:0];
      pass_done <= (i_q == LAST_POS);
    end
  end

  // checks
  a_partner_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> (j_q >= i_q) && (j_q <= LAST_POS))
    else $error("swap partner outside remaining deck");

  a_div_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_DIVIDE))
    else $error("divider finished outside divide state");

  a_restore_clears: assert property (@(posedge clk) disable iff (rst)
    (in_take && (op == OP_RESTORE)) |=> (walk == '0) && (valid_bits == '0))
    else $error("restore did not reload identity order");

  a_shuffle_starts_divider: assert property (@(posedge clk) disable iff (rst)
    (in_take && (op == OP_SHUFFLE)) |=> (state == ST_DIVIDE))
    else $error("shuffle request did not start a step");

endmodule

// File: dv/tb_top.sv
// self-checking testbench for the fisher-yates shuffle core
module tb_top;
  import fys_pkg::*;

  localparam int              DECK      = DEF_DECK_SIZE;
  localparam longint unsigned RAND_TOP  = DEF_RANDOM_MAX;
  localparam int              N_RANDOM  = 1650;
  localparam int              MAX_CYCLES = 1000000;
  localparam int              HOLD_CYCLES = 400;
  localparam int              DRAIN_CYCLES = 80;

  // one expected result of a shuffle request
  typedef struct {
    logic [POS_W-1:0]  position;
    logic [CARD_W-1:0] card;
    logic              pass_done;
  } dealt_card_t;

  // deck model plus the queue of cards still to be dealt
  class deck_predictor;
    logic [CARD_W-1:0] deck[DECK];
    int unsigned       walk;
    dealt_card_t       dealt_queue[$];
    int                errors;

    function new();
      errors = 0;
      restore_deck();
    endfunction

    function void restore_deck();
      for (int k = 0; k < DECK; k++) deck[k] = CARD_W'(k);
      walk = 0;
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function int pending();
      return dealt_queue.size();
    endfunction

    // model one accepted request
    function void note_request(op_t req_op, logic [RAND_W-1:0] word);
      longint unsigned   i, remaining, divisor, j;
      logic [CARD_W-1:0] held;
      dealt_card_t       want;
      if (req_op == OP_RESTORE) begin
        restore_deck();
        return;
      end
      i = walk;
      if (i >= DECK) i = 0;
      remaining = DECK - i;
      divisor   = RAND_TOP / remaining + 1;
      j         = i + longint'(word) / divisor;
      // an offset past the deck end saturates at the last entry
      if (j > DECK - 1) j = DECK - 1;
      held    = deck[i];
      deck[i] = deck[j];
      deck[j] = held;
      want.position  = POS_W'(i);
      want.card      = deck[i];
      want.pass_done = (i == DECK - 1);
      dealt_queue.push_back(want);
      walk = (i == DECK - 1) ? 0 : int'(i + 1);
    endfunction

    // compare one accepted result with the oldest expectation
    task check_card(logic [POS_W-1:0] got_pos, logic [CARD_W-1:0] got_card, logic got_done);
      dealt_card_t want;
      if (dealt_queue.size() == 0) begin
        report_mismatch($sformatf("result pos %0d card %0d with nothing pending",
                                  got_pos, got_card));
        return;
      end
      want = dealt_queue.pop_front();
      if (got_pos !== want.position)
        report_mismatch($sformatf("position got %0d expected %0d", got_pos, want.position));
      if (got_card !== want.card)
        report_mismatch($sformatf("card at %0d got %0d expected %0d",
                                  want.position, got_card, want.card));
      if (got_done !== want.pass_done)
        report_mismatch($sformatf("pass_done at %0d got %0b expected %0b",
                                  want.position, got_done, want.pass_done));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              op = OP_RESTORE;
  logic [RAND_W-1:0] random_word = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [POS_W-1:0]  position;
  logic [CARD_W-1:0] card;
  logic              pass_done;

  deck_predictor predictor;
  int            cycle_count = 0;
  int            results_seen = 0;

  fisher_yates_shuffle_core dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .random_word (random_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .position    (position),
    .card        (card),
    .pass_done   (pass_done)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // offer one request and hold it until taken; called at a rising edge
  task send_request(op_t req_op, logic [RAND_W-1:0] word);
    logic taken;
    in_valid    <= 1'b1;
    op          <= req_op;
    random_word <= word;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    predictor.note_request(req_op, word);
  endtask

  // drop valid for a number of cycles
  task idle_sender(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // hold off until every expected card has come
  task wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (predictor.pending() != 0) @(posedge clk);
  endtask

  // random word with weight on the edges of the range
  function logic [RAND_W-1:0] pick_word();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return RAND_W'(RAND_TOP);
      2:       return RAND_W'($urandom_range(0, 255));
      3:       return RAND_W'(RAND_TOP - $urandom_range(0, 255));
      default: return raw[RAND_W-1:0];
    endcase
  endfunction

  // main stimulus
  initial begin
    int sent;
    int burst;
    predictor = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed requests: extremes, restores mid pass and back to back
    send_request(OP_RESTORE, '0);
    send_request(OP_SHUFFLE, '0);
    send_request(OP_SHUFFLE, RAND_W'(RAND_TOP));
    send_request(OP_SHUFFLE, RAND_W'(RAND_TOP));
    send_request(OP_SHUFFLE, 31'd1);
    send_request(OP_SHUFFLE, 31'h4000_0000);
    send_request(OP_SHUFFLE, 31'h3FFF_FFFF);
    send_request(OP_SHUFFLE, 31'h2AAA_AAAA);
    send_request(OP_SHUFFLE, 31'h5555_5555);
    send_request(OP_RESTORE, 31'h7FFF_FFFF);
    send_request(OP_SHUFFLE, 31'd41297762);
    send_request(OP_SHUFFLE, 31'd42107521);
    send_request(OP_SHUFFLE, RAND_W'(RAND_TOP));
    send_request(OP_RESTORE, '0);
    send_request(OP_RESTORE, '0);
    send_request(OP_SHUFFLE, 31'd41297763);
    send_request(OP_SHUFFLE, 31'h0000_FFFF);
    send_request(OP_SHUFFLE, 31'h7FFF_0000);
    send_request(OP_RESTORE, '0);
    wait_for_drain();

    // random bursts, mostly shuffle steps so that whole passes complete
    sent = 0;
    while (sent < N_RANDOM) begin
      burst = $urandom_range(1, 30);
      for (int k = 0; k < burst; k++) begin
        if ($urandom_range(0, 199) < 3) send_request(OP_RESTORE, pick_word());
        else send_request(OP_SHUFFLE, pick_word());
        sent++;
        if (sent == N_RANDOM / 2) wait_for_drain();
      end
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 8));
    end

    // drain and settle
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (predictor.pending() != 0)
      predictor.report_mismatch($sformatf("%0d cards never dealt", predictor.pending()));
    if (predictor.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // receiver stall pattern with one long hold-off
  initial begin
    int  span;
    int  mode;
    bit  held_off;
    held_off = 1'b0;
    @(negedge rst);
    forever begin
      if (!held_off && results_seen >= 150) begin
        held_off = 1'b1;
        @(posedge clk);
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      span = $urandom_range(1, 40);
      mode = $urandom_range(0, 2);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // result monitor: values are stable ahead of the accepting edge
  initial begin
    forever begin
      @(negedge clk);
      if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
        predictor.check_card(position, card, pass_done);
        results_seen++;
      end
    end
  end

endmodule

// File: files.f
rtl/core/fys_pkg.sv
rtl/core/fys_ram.sv
rtl/core/fys_divider.sv
rtl/core/fisher_yates_shuffle_core.sv
dv/tb_top.sv
